// ===== sv/gmt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmt_pkg
// Shared types and constants of the grid mesh triangulator.
// ----------------------------------------------------------------------------
package gmt_pkg;

  localparam int unsigned DEF_MAX_COLS = 1024;
  localparam int unsigned DEF_MAX_ROWS = 1024;

  localparam int unsigned CFG_W  = 11;
  localparam int unsigned IDX_W  = 20;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned MIN_SIZE = 3;

  localparam logic [CFG_W-1:0] RST_FRAME_ROWS = 11'd480;
  localparam logic [CFG_W-1:0] RST_FRAME_COLS = 11'd640;

  localparam logic [DATA_W-1:0] EXP_MASK  = 32'h7F80_0000;
  localparam logic [DATA_W-1:0] MANT_MASK = 32'h007F_FFFF;
  localparam logic [DATA_W-1:0] MAG_MASK  = 32'h7FFF_FFFF;

  typedef enum logic {
    CFG_FRAME_ROWS = 1'b0,
    CFG_FRAME_COLS = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    REC_VERTEX   = 1'b0,
    REC_TRIANGLE = 1'b1
  } rec_kind_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
  } entry_t;

  typedef struct packed {
    rec_kind_t        kind;
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    logic [IDX_W-1:0] c;
  } rec_t;

  // Results of one pixel: vertex record first, then triangles.
  typedef struct packed {
    logic [1:0]      cnt;
    rec_t [2:0]      recs;
  } bundle_t;

  // Pixel handed from the accept stage to the quad stage.
  typedef struct packed {
    logic   vld;
    logic   quad_en;
    logic   eol;
    entry_t br;
  } pix_t;

endpackage

// ===== sv/gmt_line_buf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmt_line_buf
// Row-above line buffer: one write port, one registered read port.
// ----------------------------------------------------------------------------
module gmt_line_buf #(
  parameter int unsigned DEPTH = gmt_pkg::DEF_MAX_COLS
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  gmt_pkg::entry_t          wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output gmt_pkg::entry_t          rd_data_r
);

  gmt_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/gmt_pixel_ctl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmt_pixel_ctl
// Frame position, pixel validity and vertex index assignment; frame size regs.
// ----------------------------------------------------------------------------
module gmt_pixel_ctl #(
  parameter int unsigned MAX_COLS = gmt_pkg::DEF_MAX_COLS,
  parameter int unsigned MAX_ROWS = gmt_pkg::DEF_MAX_ROWS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  gmt_pkg::cfg_reg_t             cfg_index,
  input  logic [gmt_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          in_xfer,
  input  logic [gmt_pkg::DATA_W-1:0]    vertex_x_bits,
  input  logic [gmt_pkg::DATA_W-1:0]    normal_x_bits,
  input  logic [gmt_pkg::DATA_W-1:0]    normal_y_bits,
  input  logic [gmt_pkg::DATA_W-1:0]    normal_z_bits,
  input  logic                          advance,
  output logic [$clog2(MAX_COLS)-1:0]   rd_addr,
  output gmt_pkg::pix_t                 pix_r,
  output logic [$clog2(MAX_COLS)-1:0]   waddr_r
);

  localparam int unsigned CW = $clog2(MAX_COLS);
  localparam int unsigned RW = $clog2(MAX_ROWS);

  // Clamped size minus one, i.e. the last column / row.
  function automatic logic [31:0] last_pos(input logic [gmt_pkg::CFG_W-1:0] v,
                                           input int unsigned hi);
    logic [31:0] w;
    begin
      w = 32'(v);
      if (w < gmt_pkg::MIN_SIZE) begin
        w = gmt_pkg::MIN_SIZE;
      end else if (w > hi) begin
        w = hi;
      end
      return w - 32'd1;
    end
  endfunction

  localparam logic [CW-1:0] RST_COL_LAST = CW'(last_pos(gmt_pkg::RST_FRAME_COLS, MAX_COLS));
  localparam logic [RW-1:0] RST_ROW_LAST = RW'(last_pos(gmt_pkg::RST_FRAME_ROWS, MAX_ROWS));

  logic [CW-1:0]             col_r, col_nxt, col_last_r;
  logic [RW-1:0]             row_r, row_nxt, row_last_r;
  logic [gmt_pkg::IDX_W-1:0] idx_r, idx_nxt;
  gmt_pkg::pix_t             pix_nxt;
  logic                      is_nan, zero_norm, in_frame, px_ok;

  always_comb begin
    is_nan    = ((vertex_x_bits & gmt_pkg::EXP_MASK) == gmt_pkg::EXP_MASK) &&
                ((vertex_x_bits & gmt_pkg::MANT_MASK) != '0);
    zero_norm = ((normal_x_bits & gmt_pkg::MAG_MASK) == '0) &&
                ((normal_y_bits & gmt_pkg::MAG_MASK) == '0) &&
                ((normal_z_bits & gmt_pkg::MAG_MASK) == '0);
    in_frame  = (row_r != '0) && (row_r != row_last_r) &&
                (col_r != '0) && (col_r != col_last_r);
    px_ok     = in_frame && !is_nan && !zero_norm;

    pix_nxt.vld       = 1'b1;
    pix_nxt.quad_en   = (row_r >= RW'(2)) && (col_r >= CW'(2));
    pix_nxt.eol       = (col_r == col_last_r);
    pix_nxt.br.valid  = px_ok;
    pix_nxt.br.idx    = px_ok ? idx_r : '0;

    idx_nxt = idx_r + gmt_pkg::IDX_W'(px_ok);
    col_nxt = col_r + CW'(1);
    row_nxt = row_r;
    if (pix_nxt.eol) begin
      col_nxt = '0;
      if (row_r == row_last_r) begin
        row_nxt = '0;
        idx_nxt = '0;
      end else begin
        row_nxt = row_r + RW'(1);
      end
    end
  end

  assign rd_addr = col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      idx_r      <= '0;
      col_last_r <= RST_COL_LAST;
      row_last_r <= RST_ROW_LAST;
      pix_r      <= '0;
    end else if (cfg_wr_en) begin
      col_r     <= '0;
      row_r     <= '0;
      idx_r     <= '0;
      pix_r.vld <= 1'b0;
      unique case (cfg_index)
        gmt_pkg::CFG_FRAME_ROWS: row_last_r <= RW'(last_pos(cfg_wdata, MAX_ROWS));
        gmt_pkg::CFG_FRAME_COLS: col_last_r <= CW'(last_pos(cfg_wdata, MAX_COLS));
        default: ;
      endcase
    end else if (in_xfer) begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      idx_r   <= idx_nxt;
      pix_r   <= pix_nxt;
      waddr_r <= col_r;
    end else if (advance) begin
      pix_r.vld <= 1'b0;
    end
  end

endmodule

// ===== sv/gmt_quad.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmt_quad
// Quad stage: forms triangles from the 2x2 neighborhood, updates the line
// buffer and the left / upper-left entries.
// ----------------------------------------------------------------------------
module gmt_quad #(
  parameter int unsigned MAX_COLS = gmt_pkg::DEF_MAX_COLS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        restart,
  input  gmt_pkg::pix_t               pix,
  input  logic [$clog2(MAX_COLS)-1:0] pix_addr,
  input  gmt_pkg::entry_t             tr,
  input  logic                        out_free,
  output logic                        fire,
  output logic                        wr_en,
  output logic [$clog2(MAX_COLS)-1:0] wr_addr,
  output gmt_pkg::entry_t             wr_data,
  output gmt_pkg::bundle_t            bundle
);

  gmt_pkg::entry_t ul_r, ul_nxt, left_r, left_nxt;
  gmt_pkg::rec_t   t0, t1, vrec;
  logic [1:0]      ntri;
  gmt_pkg::entry_t tl, bl, br;

  assign tl = ul_r;
  assign bl = left_r;
  assign br = pix.br;

  assign fire    = pix.vld && out_free;
  assign wr_en   = fire;
  assign wr_addr = pix_addr;
  assign wr_data = br;

  always_comb begin
    t0   = '{kind: gmt_pkg::REC_TRIANGLE, a: tl.idx, b: tr.idx, c: bl.idx};
    t1   = '{kind: gmt_pkg::REC_TRIANGLE, a: tr.idx, b: br.idx, c: bl.idx};
    ntri = 2'd0;
    if (pix.quad_en) begin
      case ({tl.valid, tr.valid, bl.valid, br.valid})
        4'b1111: ntri = 2'd2;
        4'b1110: ntri = 2'd1;
        4'b1101: begin
          ntri = 2'd1;
          t0.c = br.idx;
        end
        4'b1011: begin
          ntri = 2'd1;
          t0.b = br.idx;
        end
        4'b0111: begin
          ntri = 2'd1;
          t0   = t1;
        end
        default: ntri = 2'd0;
      endcase
    end

    vrec = '{kind: gmt_pkg::REC_VERTEX, a: br.idx, b: '0, c: '0};
    bundle.cnt = ntri + 2'(br.valid);
    if (br.valid) begin
      bundle.recs[0] = vrec;
      bundle.recs[1] = t0;
      bundle.recs[2] = t1;
    end else begin
      bundle.recs[0] = t0;
      bundle.recs[1] = t1;
      bundle.recs[2] = t1;
    end

    ul_nxt   = pix.eol ? '0 : tr;
    left_nxt = pix.eol ? '0 : br;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      ul_r   <= '0;
      left_r <= '0;
    end else if (fire) begin
      ul_r   <= ul_nxt;
      left_r <= left_nxt;
    end
  end

endmodule

// ===== sv/gmt_emit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmt_emit
// Result serializer: holds one pixel's records and presents one per transfer.
// ----------------------------------------------------------------------------
module gmt_emit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      load,
  input  gmt_pkg::bundle_t          bundle,
  output logic                      free,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_record_kind,
  output logic [gmt_pkg::IDX_W-1:0] out_corner_a,
  output logic [gmt_pkg::IDX_W-1:0] out_corner_b,
  output logic [gmt_pkg::IDX_W-1:0] out_corner_c,
  output logic                      out_last_of_pixel
);

  gmt_pkg::bundle_t bundle_r;
  logic             busy_r;
  logic [1:0]       ptr_r;
  logic             last;
  gmt_pkg::rec_t    cur;

  assign last      = (ptr_r == bundle_r.cnt - 2'd1);
  assign out_valid = busy_r;
  assign free      = !busy_r || (out_ready && last);

  always_comb begin
    case (ptr_r)
      2'd0:    cur = bundle_r.recs[0];
      2'd1:    cur = bundle_r.recs[1];
      default: cur = bundle_r.recs[2];
    endcase
  end

  assign out_record_kind   = cur.kind;
  assign out_corner_a      = cur.a;
  assign out_corner_b      = cur.b;
  assign out_corner_c      = cur.c;
  assign out_last_of_pixel = last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ptr_r  <= '0;
    end else if (load && bundle.cnt != 2'd0) begin
      busy_r <= 1'b1;
      ptr_r  <= '0;
    end else if (busy_r && out_ready) begin
      if (last) begin
        busy_r <= 1'b0;
      end
      ptr_r <= ptr_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bundle_r <= bundle;
    end
  end

endmodule

// ===== sv/grid_mesh_triangulator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_mesh_triangulator_top
// Streaming triangulation of an organized point cloud, one pixel per transfer.
// ----------------------------------------------------------------------------
// Pixels enter row-major; each valid pixel yields a vertex record and the
// pixel that closes a 2x2 quad yields up to two triangle records, so one
// pixel causes zero to three result transfers. A pixel passes through the
// accept stage (line buffer read issued) and then the quad stage; the
// output serializer sends one record per cycle while out_ready is high; a
// pixel with more than one record keeps the next one in the quad stage.
// The next pixel is taken while the previous one's records drain. The row
// buffer needs no clearing after reset. Writing frame_rows or frame_cols
// restarts the frame; do so only while the block is idle.
module grid_mesh_triangulator_top #(
  parameter int unsigned MAX_COLS = gmt_pkg::DEF_MAX_COLS,
  parameter int unsigned MAX_ROWS = gmt_pkg::DEF_MAX_ROWS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic                      cfg_index,
  input  logic [gmt_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [31:0]               in_vertex_x_bits,
  input  logic [31:0]               in_normal_x_bits,
  input  logic [31:0]               in_normal_y_bits,
  input  logic [31:0]               in_normal_z_bits,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_record_kind,
  output logic [19:0]               out_corner_a,
  output logic [19:0]               out_corner_b,
  output logic [19:0]               out_corner_c,
  output logic                      out_last_of_pixel
);

  localparam int unsigned CW = $clog2(MAX_COLS);

  logic             in_xfer, fire, out_free, wr_en;
  logic [CW-1:0]    rd_addr, waddr, wr_addr;
  gmt_pkg::pix_t    pix;
  gmt_pkg::entry_t  tr, wr_data;
  gmt_pkg::bundle_t bundle;

  assign in_ready = !pix.vld || out_free;
  assign in_xfer  = in_valid && in_ready;

  gmt_pixel_ctl #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_pixel_ctl (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (gmt_pkg::cfg_reg_t'(cfg_index)),
    .cfg_wdata     (cfg_wdata),
    .in_xfer       (in_xfer),
    .vertex_x_bits (in_vertex_x_bits),
    .normal_x_bits (in_normal_x_bits),
    .normal_y_bits (in_normal_y_bits),
    .normal_z_bits (in_normal_z_bits),
    .advance       (fire),
    .rd_addr       (rd_addr),
    .pix_r         (pix),
    .waddr_r       (waddr)
  );

  gmt_line_buf #(
    .DEPTH (MAX_COLS)
  ) u_line_buf (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (in_xfer),
    .rd_addr   (rd_addr),
    .rd_data_r (tr)
  );

  gmt_quad #(
    .MAX_COLS (MAX_COLS)
  ) u_quad (
    .clk      (clk),
    .rst_n    (rst_n),
    .restart  (cfg_wr_en),
    .pix      (pix),
    .pix_addr (waddr),
    .tr       (tr),
    .out_free (out_free),
    .fire     (fire),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .bundle   (bundle)
  );

  gmt_emit u_emit (
    .clk               (clk),
    .rst_n             (rst_n),
    .load              (fire),
    .bundle            (bundle),
    .free              (out_free),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_record_kind   (out_record_kind),
    .out_corner_a      (out_corner_a),
    .out_corner_b      (out_corner_b),
    .out_corner_c      (out_corner_c),
    .out_last_of_pixel (out_last_of_pixel)
  );

endmodule

// ===== tb/sv/gmt_mesh_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmt_mesh_checker
// Watches the pixel, result and register ports of the grid mesh triangulator,
// computes the vertex and triangle records each accepted pixel must produce,
// and compares every result transfer with the oldest outstanding record.
// ----------------------------------------------------------------------------
module gmt_mesh_checker #(
  parameter int unsigned MAX_COLS = gmt_pkg::DEF_MAX_COLS,
  parameter int unsigned MAX_ROWS = gmt_pkg::DEF_MAX_ROWS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic                      cfg_index,
  input  logic [gmt_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [31:0]               in_vertex_x_bits,
  input  logic [31:0]               in_normal_x_bits,
  input  logic [31:0]               in_normal_y_bits,
  input  logic [31:0]               in_normal_z_bits,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic                      out_record_kind,
  input  logic [19:0]               out_corner_a,
  input  logic [19:0]               out_corner_b,
  input  logic [19:0]               out_corner_c,
  input  logic                      out_last_of_pixel,
  output int unsigned               mismatch_count,
  output int unsigned               records_pending
);

  localparam int unsigned IW    = gmt_pkg::IDX_W;
  localparam int unsigned CFG_W = gmt_pkg::CFG_W;

  typedef struct {
    gmt_pkg::rec_kind_t kind;
    logic [IW-1:0]      a;
    logic [IW-1:0]      b;
    logic [IW-1:0]      c;
    logic               last;
  } mesh_rec_t;

  logic [CFG_W-1:0] rows_reg;
  logic [CFG_W-1:0] cols_reg;
  gmt_pkg::entry_t  row_above [MAX_COLS];
  gmt_pkg::entry_t  up_left;
  gmt_pkg::entry_t  left_nb;
  int unsigned      row_pos;
  int unsigned      col_pos;
  logic [IW-1:0]    next_idx;
  mesh_rec_t        expected_records[$];

  function automatic int unsigned clamp_dim(logic [CFG_W-1:0] v, int unsigned hi);
    if (v < gmt_pkg::MIN_SIZE) return gmt_pkg::MIN_SIZE;
    if (v > hi) return hi;
    return 32'(v);
  endfunction

  task automatic restart_frame();
    up_left  = '0;
    left_nb  = '0;
    row_pos  = 0;
    col_pos  = 0;
    next_idx = '0;
  endtask

  task automatic push_record(gmt_pkg::rec_kind_t kind, gmt_pkg::entry_t a,
                             gmt_pkg::entry_t b, gmt_pkg::entry_t c);
    mesh_rec_t r;
    r.kind = kind;
    r.a    = a.idx;
    r.b    = b.idx;
    r.c    = c.idx;
    r.last = 1'b0;
    expected_records.insert(expected_records.size(), r);
  endtask

  task automatic triangulate_pixel(input logic [31:0] vx, input logic [31:0] nx,
                                   input logic [31:0] ny, input logic [31:0] nz);
    int unsigned     n_rows;
    int unsigned     n_cols;
    int unsigned     produced;
    logic            in_frame;
    logic            is_nan;
    logic            zero_norm;
    gmt_pkg::entry_t tl;
    gmt_pkg::entry_t tr;
    gmt_pkg::entry_t bl;
    gmt_pkg::entry_t br;
    n_rows    = clamp_dim(rows_reg, MAX_ROWS);
    n_cols    = clamp_dim(cols_reg, MAX_COLS);
    produced  = 0;
    in_frame  = row_pos >= 1 && row_pos + 1 < n_rows && col_pos >= 1 && col_pos + 1 < n_cols;
    is_nan    = (vx & gmt_pkg::EXP_MASK) == gmt_pkg::EXP_MASK &&
                (vx & gmt_pkg::MANT_MASK) != '0;
    zero_norm = (nx & gmt_pkg::MAG_MASK) == '0 && (ny & gmt_pkg::MAG_MASK) == '0 &&
                (nz & gmt_pkg::MAG_MASK) == '0;
    br = '0;
    if (in_frame && !is_nan && !zero_norm) begin
      br.valid = 1'b1;
      br.idx   = next_idx;
      next_idx = next_idx + IW'(1);
      push_record(gmt_pkg::REC_VERTEX, br, '0, '0);
      produced++;
    end
    tr = row_above[col_pos % MAX_COLS];
    tl = up_left;
    bl = left_nb;
    // corner order of the mask: tl tr bl br
    if (row_pos >= 2 && col_pos >= 2) begin
      case ({tl.valid, tr.valid, bl.valid, br.valid})
        4'b1111: begin
          push_record(gmt_pkg::REC_TRIANGLE, tl, tr, bl);
          push_record(gmt_pkg::REC_TRIANGLE, tr, br, bl);
          produced += 2;
        end
        4'b1110: begin
          push_record(gmt_pkg::REC_TRIANGLE, tl, tr, bl);
          produced++;
        end
        4'b1101: begin
          push_record(gmt_pkg::REC_TRIANGLE, tl, tr, br);
          produced++;
        end
        4'b1011: begin
          push_record(gmt_pkg::REC_TRIANGLE, tl, br, bl);
          produced++;
        end
        4'b0111: begin
          push_record(gmt_pkg::REC_TRIANGLE, tr, br, bl);
          produced++;
        end
        default: ;
      endcase
    end
    row_above[col_pos % MAX_COLS] = br;
    up_left = tr;
    left_nb = br;
    if (col_pos + 1 >= n_cols) begin
      col_pos = 0;
      up_left = '0;
      left_nb = '0;
      if (row_pos + 1 >= n_rows) begin
        row_pos  = 0;
        next_idx = '0;
      end else begin
        row_pos++;
      end
    end else begin
      col_pos++;
    end
    if (produced > 0) expected_records[expected_records.size()-1].last = 1'b1;
  endtask

  task automatic compare_field(string name, logic [IW-1:0] expv, logic [IW-1:0] actv);
    if (actv !== expv) begin
      $error("%s mismatch: expected %0h actual %0h", name, expv, actv);
      mismatch_count++;
    end
  endtask

  task automatic check_record();
    mesh_rec_t want;
    if (expected_records.size() == 0) begin
      $error("record transfer with none outstanding: kind %0d corners %0h %0h %0h",
             out_record_kind, out_corner_a, out_corner_b, out_corner_c);
      mismatch_count++;
      return;
    end
    want = expected_records.pop_front();
    compare_field("record_kind", IW'(want.kind), IW'(out_record_kind));
    compare_field("corner_a", want.a, out_corner_a);
    compare_field("corner_b", want.b, out_corner_b);
    compare_field("corner_c", want.c, out_corner_c);
    compare_field("last_of_pixel", IW'(want.last), IW'(out_last_of_pixel));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      rows_reg = gmt_pkg::RST_FRAME_ROWS;
      cols_reg = gmt_pkg::RST_FRAME_COLS;
      foreach (row_above[i]) row_above[i] = '0;
      restart_frame();
      expected_records.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == gmt_pkg::CFG_FRAME_ROWS) rows_reg = cfg_wdata;
        else cols_reg = cfg_wdata;
        restart_frame();
      end
      if (in_valid && in_ready)
        triangulate_pixel(in_vertex_x_bits, in_normal_x_bits, in_normal_y_bits,
                          in_normal_z_bits);
      if (out_valid && out_ready) check_record();
    end
    records_pending <= expected_records.size();
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Pixel stream stimulus for the grid mesh triangulator: hand-built frames, a
// run of small random frame sizes with random pixel content, and the frame
// size extremes, under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned CFG_W         = gmt_pkg::CFG_W;
  localparam int unsigned RANDOM_ITEMS  = 200;
  localparam int unsigned EXTREME_ITEMS = 24;
  localparam int unsigned IDLE_LIMIT    = 2000;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned DRAIN_CYCLES  = 16;

  typedef struct packed {
    logic [31:0] vx;
    logic [31:0] nx;
    logic [31:0] ny;
    logic [31:0] nz;
  } pixel_t;

  typedef enum int unsigned {RX_FREE, RX_COIN, RX_SPARSE, RX_BEAT} rx_mode_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_wr_en;
  logic             cfg_index;
  logic [CFG_W-1:0] cfg_wdata;
  logic             in_valid;
  logic             in_ready;
  logic [31:0]      in_vertex_x_bits;
  logic [31:0]      in_normal_x_bits;
  logic [31:0]      in_normal_y_bits;
  logic [31:0]      in_normal_z_bits;
  logic             out_valid;
  logic             out_ready;
  logic             out_record_kind;
  logic [19:0]      out_corner_a;
  logic [19:0]      out_corner_b;
  logic [19:0]      out_corner_c;
  logic             out_last_of_pixel;
  int unsigned      mismatches;
  int unsigned      records_pending;

  int unsigned      burst_left = 0;
  int unsigned      hold_reqs = 0;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  grid_mesh_triangulator_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_vertex_x_bits  (in_vertex_x_bits),
    .in_normal_x_bits  (in_normal_x_bits),
    .in_normal_y_bits  (in_normal_y_bits),
    .in_normal_z_bits  (in_normal_z_bits),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_record_kind   (out_record_kind),
    .out_corner_a      (out_corner_a),
    .out_corner_b      (out_corner_b),
    .out_corner_c      (out_corner_c),
    .out_last_of_pixel (out_last_of_pixel)
  );

  gmt_mesh_checker u_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_vertex_x_bits  (in_vertex_x_bits),
    .in_normal_x_bits  (in_normal_x_bits),
    .in_normal_y_bits  (in_normal_y_bits),
    .in_normal_z_bits  (in_normal_z_bits),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_record_kind   (out_record_kind),
    .out_corner_a      (out_corner_a),
    .out_corner_b      (out_corner_b),
    .out_corner_c      (out_corner_c),
    .out_last_of_pixel (out_last_of_pixel),
    .mismatch_count    (mismatches),
    .records_pending   (records_pending)
  );

  function automatic pixel_t make_pixel();
    pixel_t      p;
    logic [22:0] mant;
    int unsigned pick;
    p.vx = $urandom;
    p.nx = $urandom;
    p.ny = $urandom;
    p.nz = $urandom;
    pick = $urandom_range(0, 99);
    mant = 23'($urandom_range(1, 32'h007F_FFFF));
    if (pick < 12) begin
      p.vx = {p.vx[31], 8'hFF, mant};
    end else if (pick < 24) begin
      p.nx &= ~gmt_pkg::MAG_MASK;
      p.ny &= ~gmt_pkg::MAG_MASK;
      p.nz &= ~gmt_pkg::MAG_MASK;
    end else if (pick < 34) begin
      p.vx = {p.vx[31], 8'hFF, 23'h0};
      case ($urandom_range(0, 2))
        0: begin p.nx &= ~gmt_pkg::MAG_MASK; p.ny &= ~gmt_pkg::MAG_MASK; end
        1: begin p.ny &= ~gmt_pkg::MAG_MASK; p.nz &= ~gmt_pkg::MAG_MASK; end
        default: begin p.nx &= ~gmt_pkg::MAG_MASK; p.nz &= ~gmt_pkg::MAG_MASK; end
      endcase
    end
    return p;
  endfunction

  function automatic int unsigned dim_of(logic [CFG_W-1:0] v, int unsigned hi);
    if (v < gmt_pkg::MIN_SIZE) return gmt_pkg::MIN_SIZE;
    if (v > hi) return hi;
    return 32'(v);
  endfunction

  // called on a falling edge, returns on the falling edge after the transfer
  task automatic drive_pixel(input pixel_t p);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 48 : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid         <= 1'b1;
    in_vertex_x_bits <= p.vx;
    in_normal_x_bits <= p.nx;
    in_normal_y_bits <= p.ny;
    in_normal_z_bits <= p.nz;
    do @(posedge clk); while (in_ready !== 1'b1);
    @(negedge clk);
  endtask

  task automatic write_reg(input gmt_pkg::cfg_reg_t idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (records_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // receiver: stall pattern changes every so often; hold-off on request
  initial begin
    rx_mode_t    mode;
    int unsigned mode_left;
    int unsigned holds_done;
    int unsigned beat;
    out_ready  = 1'b0;
    mode       = RX_FREE;
    mode_left  = 0;
    holds_done = 0;
    beat       = 0;
    forever begin
      @(negedge clk);
      if (holds_done != hold_reqs) begin
        holds_done++;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 150);
        end
        mode_left--;
        beat++;
        case (mode)
          RX_FREE:   out_ready <= 1'b1;
          RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
          default:   out_ready <= (beat % 8) < 5;
        endcase
      end
    end
  end

  // no transfer for too long: hung
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en || !rst_n)
        quiet = 0;
      else
        quiet++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    pixel_t           p;
    int unsigned      sent;
    int unsigned      n_items;
    int unsigned      frame_px;
    logic [CFG_W-1:0] cur_rows;
    logic [CFG_W-1:0] cur_cols;
    rst_n            = 1'b0;
    cfg_wr_en        = 1'b0;
    cfg_index        = gmt_pkg::CFG_FRAME_ROWS;
    cfg_wdata        = '0;
    in_valid         = 1'b0;
    in_vertex_x_bits = '0;
    in_normal_x_bits = '0;
    in_normal_y_bits = '0;
    in_normal_z_bits = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // 4x4 frame: one quad, all corners valid, first index in the quad
    write_reg(gmt_pkg::CFG_FRAME_ROWS, 11'd4);
    write_reg(gmt_pkg::CFG_FRAME_COLS, 11'd4);
    for (int i = 0; i < 16; i++) begin
      p = '{32'h3F80_0000, 32'h0, 32'h0, 32'hBF80_0000};
      case (i)
        0:  p = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
        5:  p = '{32'h7F80_0000, 32'h8000_0000, 32'h8000_0000, 32'h0000_0001};
        6:  p = '{32'hFF80_0000, 32'h0, 32'h0, 32'h8000_0001};
        9:  p = '{32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0};
        10: p = '{32'h7F7F_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
        15: p = '{32'h0, 32'h0, 32'h0, 32'h0};
        default: ;
      endcase
      drive_pixel(p);
    end
    wait_idle();

    // 4x3 frame: NaN vertex, then signed-zero normal
    write_reg(gmt_pkg::CFG_FRAME_COLS, 11'd3);
    for (int i = 0; i < 12; i++) begin
      p = make_pixel();
      if (i == 4) p = '{32'h7F80_0001, 32'h3F80_0000, 32'h0, 32'h0};
      if (i == 7) p = '{32'h3F80_0000, 32'h8000_0000, 32'h0, 32'h8000_0000};
      drive_pixel(p);
    end
    wait_idle();

    // random frame sizes, some phases cut mid-frame by the next write
    cur_rows = 11'd4;
    cur_cols = 11'd3;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 3))
        0: cur_rows = CFG_W'($urandom_range(0, 8));
        1: cur_cols = CFG_W'($urandom_range(0, 9));
        default: begin
          cur_rows = CFG_W'($urandom_range(0, 8));
          cur_cols = CFG_W'($urandom_range(0, 9));
        end
      endcase
      write_reg(gmt_pkg::CFG_FRAME_ROWS, cur_rows);
      write_reg(gmt_pkg::CFG_FRAME_COLS, cur_cols);
      frame_px = dim_of(cur_rows, gmt_pkg::DEF_MAX_ROWS) *
                 dim_of(cur_cols, gmt_pkg::DEF_MAX_COLS);
      n_items  = frame_px + $urandom_range(0, frame_px);
      for (int i = 0; i < n_items; i++) begin
        if (sent == 60 || sent == 150) hold_reqs++;
        drive_pixel(make_pixel());
        sent++;
      end
      wait_idle();
    end

    // size extremes: widest frame, then tallest, each cut short
    write_reg(gmt_pkg::CFG_FRAME_ROWS, 11'd0);
    write_reg(gmt_pkg::CFG_FRAME_COLS, 11'h7FF);
    repeat (EXTREME_ITEMS) drive_pixel(make_pixel());
    wait_idle();
    write_reg(gmt_pkg::CFG_FRAME_ROWS, 11'h7FF);
    write_reg(gmt_pkg::CFG_FRAME_COLS, 11'd1);
    repeat (EXTREME_ITEMS) drive_pixel(make_pixel());
    wait_idle();

    if (mismatches == 0 && records_pending == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
